@@ rtl/sct_pkg.sv @@
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and codes for the support count table: payload structs, op
// codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package sct_pkg;

  typedef enum logic [1:0] {
    OP_ACCUM  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_PRUNE  = 2'd2,
    OP_NONE   = 2'd3
  } op_e_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] item_id;
    logic [15:0] add_count;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] support;
    logic [5:0]  position;
    logic        table_full;
    logic [6:0]  entries_used;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } sct_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sct_stat_t;

endpackage

@@ rtl/sct_ctrl.sv @@
// ----------------------------------------------------------------------------
// sct_ctrl
// Sequencer: takes one op, runs the table scan, then issues the finishing
// update once the result register is free.
// ----------------------------------------------------------------------------
module sct_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  sct_pkg::sct_stat_t stat,
  output sct_pkg::sct_cmd_t  cmd
);
  import sct_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/sct_dp.sv @@
// ----------------------------------------------------------------------------
// sct_dp
// Datapath: id and support memories, pipelined scan with one read per cycle,
// in-place compaction for prune, saturating add and the result register.
// ----------------------------------------------------------------------------
module sct_dp #(
  parameter int TABLE_DEPTH   = 64,
  parameter int ID_WIDTH      = 16,
  parameter int SUPPORT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sct_pkg::in_item_t  in_data,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_data,
  input  sct_pkg::sct_cmd_t  cmd,
  output sct_pkg::sct_stat_t stat,
  output logic               out_valid,
  input  logic               out_ready,
  output sct_pkg::out_item_t out_data
);
  import sct_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int SW   = SUPPORT_WIDTH;
  localparam int SUMW = ((SW > 16) ? SW : 16) + 1;

  logic [ID_WIDTH-1:0] id_mem  [TABLE_DEPTH];
  logic [SW-1:0]       sup_mem [TABLE_DEPTH];

  logic [1:0]          op_r;
  logic [ID_WIDTH-1:0] key_r;
  logic [15:0]         add_r;
  logic [CW-1:0]       scan_r;
  logic                q_vld_r;
  logic [AW-1:0]       q_idx_r;
  logic [ID_WIDTH-1:0] id_q_r;
  logic [SW-1:0]       sup_q_r;
  logic                hit_r;
  logic [AW-1:0]       hit_idx_r;
  logic [SW-1:0]       hit_sup_r;
  logic [CW-1:0]       wr_r;
  logic [CW-1:0]       count_r;
  logic [CW-1:0]       count_nxt;
  logic [31:0]         min_sup_r;
  logic                out_valid_r;
  out_item_t           out_r;
  out_item_t           res;

  logic                issue;
  logic                hit_now;
  logic                keep;
  logic                room;
  logic [SUMW-1:0]     sum;
  logic [SW-1:0]       new_sup;
  logic                we_id;
  logic                we_sup;
  logic [AW-1:0]       waddr;
  logic [ID_WIDTH-1:0] wid;
  logic [SW-1:0]       wsup;
  logic [63:0]         sup_ext;
  logic [31:0]         pos_ext;
  logic [31:0]         cnt_ext;
  logic [SW-1:0]       res_sup;
  logic [AW-1:0]       res_pos;

  assign hit_now = q_vld_r && (op_r == OP_ACCUM || op_r == OP_LOOKUP) && (id_q_r == key_r);
  assign issue   = cmd.scan && (scan_r != count_r) && !hit_r && !hit_now && (op_r != OP_NONE);
  assign keep    = q_vld_r && (op_r == OP_PRUNE) && (64'(sup_q_r) >= 64'(min_sup_r));
  assign room    = (count_r != CW'(TABLE_DEPTH));

  // saturating add: any carry above the support width means overflow
  assign sum     = SUMW'(hit_r ? hit_sup_r : '0) + SUMW'(add_r);
  assign new_sup = (|sum[SUMW-1:SW]) ? {SW{1'b1}} : sum[SW-1:0];

  assign stat.scan_done = (op_r == OP_NONE) || hit_r || (!q_vld_r && scan_r == count_r);
  assign stat.out_free  = !out_valid_r || out_ready;

  always_comb begin
    we_id     = 1'b0;
    we_sup    = 1'b0;
    waddr     = wr_r[AW-1:0];
    wid       = id_q_r;
    wsup      = sup_q_r;
    count_nxt = count_r;
    res_sup   = '0;
    res_pos   = '0;
    res       = '0;
    if (keep) begin
      we_id  = 1'b1;
      we_sup = 1'b1;
    end
    if (cmd.finish) begin
      unique case (op_r)
        OP_ACCUM: begin
          if (hit_r) begin
            we_sup    = 1'b1;
            waddr     = hit_idx_r;
            wsup      = new_sup;
            res.found = 1'b1;
            res_sup   = new_sup;
            res_pos   = hit_idx_r;
          end else if (room) begin
            we_id     = 1'b1;
            we_sup    = 1'b1;
            waddr     = count_r[AW-1:0];
            wid       = key_r;
            wsup      = new_sup;
            count_nxt = count_r + CW'(1);
            res_sup   = new_sup;
            res_pos   = count_r[AW-1:0];
          end else begin
            res.table_full = 1'b1;
          end
        end
        OP_LOOKUP: begin
          if (hit_r) begin
            res.found = 1'b1;
            res_sup   = hit_sup_r;
            res_pos   = hit_idx_r;
          end
        end
        OP_PRUNE: begin
          count_nxt = wr_r;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
    sup_ext          = 64'(res_sup);
    pos_ext          = 32'(res_pos);
    cnt_ext          = 32'(count_nxt);
    res.support      = sup_ext[31:0];
    res.position     = pos_ext[5:0];
    res.entries_used = cnt_ext[6:0];
  end

  // table storage, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (we_id) begin
      id_mem[waddr] <= wid;
    end
    if (we_sup) begin
      sup_mem[waddr] <= wsup;
    end
    id_q_r  <= id_mem[scan_r[AW-1:0]];
    sup_q_r <= sup_mem[scan_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= in_data.op;
      key_r <= ID_WIDTH'(in_data.item_id);
      add_r <= in_data.add_count;
    end
    q_idx_r <= scan_r[AW-1:0];
    if (hit_now) begin
      hit_idx_r <= q_idx_r;
      hit_sup_r <= sup_q_r;
    end
    if (cmd.finish) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r      <= '0;
      q_vld_r     <= 1'b0;
      hit_r       <= 1'b0;
      wr_r        <= '0;
      count_r     <= '0;
      min_sup_r   <= 32'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_sup_r <= cfg_data;
      end
      if (cmd.load) begin
        scan_r  <= '0;
        q_vld_r <= 1'b0;
        hit_r   <= 1'b0;
        wr_r    <= '0;
      end else begin
        q_vld_r <= issue;
        if (issue) begin
          scan_r <= scan_r + CW'(1);
        end
        if (hit_now) begin
          hit_r <= 1'b1;
        end
        if (keep) begin
          wr_r <= wr_r + CW'(1);
        end
      end
      count_r <= count_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/support_count_table.sv @@
// ----------------------------------------------------------------------------
// support_count_table
// Ordered header table of item ids with saturating support counts.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready/in_data) carries one op per transfer:
//   accumulate, lookup or prune. each op gives exactly one transfer on the
//   result channel (out_valid/out_ready/out_data).
//   cfg_valid/cfg_data writes min_support; cfg_ready is always high. write it
//   only while no op is in flight.
// sequencing:
//   one op at a time. the scan reads one entry per cycle from the registered
//   read port of the id/support memories; a finishing step then writes back
//   and loads the result register once it is free, and only then is the
//   next op taken. a hit at position p reads p + 1 entries; a prune walks
//   every valid entry and compacts survivors in place.
// reset:
//   rst_n (synchronous, active low) empties the table, sets min_support to 1
//   and drops any pending result. no clearing pass: the entry count alone
//   marks which memory entries are live.
// stalls:
//   the result register holds a finished result while out_ready is low; the
//   next op is still accepted and scanned, and waits only to deliver.
// ----------------------------------------------------------------------------
module support_count_table #(
  parameter int TABLE_DEPTH   = 64,
  parameter int ID_WIDTH      = 16,
  parameter int SUPPORT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sct_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sct_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);
  import sct_pkg::*;

  sct_cmd_t  cmd;
  sct_stat_t stat;

  // register writes never stall
  assign cfg_ready = 1'b1;

  // sequencer: idle -> scan -> finish
  sct_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // table memories, scan pipeline and result register
  sct_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .ID_WIDTH      (ID_WIDTH),
    .SUPPORT_WIDTH (SUPPORT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/sct_checker.sv @@
// ----------------------------------------------------------------------------
// sct_checker
// Port-level checks for the support count table, bound to the top level.
// ----------------------------------------------------------------------------
module sct_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input sct_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input sct_pkg::out_item_t out_data
);
  import sct_pkg::*;

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // stalled result keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // one op at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second op taken while busy");

  // a dropped append never reports a hit
  a_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.found && out_data.table_full))
    else $error("found and table_full together");

  // a dropped append reports no support or position
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.table_full |-> out_data.support == 32'd0 &&
                                         out_data.position == 6'd0)
    else $error("table_full with nonzero fields");

endmodule

bind support_count_table sct_checker u_sct_checker (.*);
